// ----- src/lcd4_pkg.sv -----
// ----------------------------------------------------------------------------
// lcd4_pkg
// Types, command codes and constant tables shared by the 4-bit character LCD
// front end.
// ----------------------------------------------------------------------------
package lcd4_pkg;

    // Request codes.
    localparam logic [2:0] CMD_DATA   = 3'd0;
    localparam logic [2:0] CMD_BYTE   = 3'd1;
    localparam logic [2:0] CMD_CURSOR = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_PRINT  = 3'd4;
    localparam logic [2:0] CMD_INIT   = 3'd5;

    // Register-select values.
    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    // Display command bytes and limits.
    localparam logic [7:0] LCD_CLEAR      = 8'h01;
    localparam logic [7:0] CURSOR_FLAG    = 8'h80;
    localparam logic [7:0] ASCII_ZERO     = 8'h30;
    localparam logic [2:0] ROW_MAX        = 3'd3;
    localparam logic [4:0] COL_MAX        = 5'd19;
    localparam logic [2:0] INIT_LAST_STEP = 3'd6;

    // Reciprocal of ten: floor(v * RECIP10 / 2^35) == v / 10 for any 32-bit v.
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam logic [31:0] TEN         = 32'd10;

    // Byte queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  byte_value;
        logic [2:0]  row;
        logic [4:0]  column;
        logic [31:0] number;
    } t_req;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic [4:0] wait_before_ms;
        logic       last;
    } t_result;

    // One queued byte: sent by the back part as two nibble strobes.
    typedef struct packed {
        logic       reg_select;
        logic [7:0] data;
        logic [4:0] wait_ms;
        logic       last;
    } t_qentry;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        case (row)
            2'd0:    base = 8'h00;
            2'd1:    base = 8'h40;
            2'd2:    base = 8'h14;
            default: base = 8'h54;
        endcase
        return base;
    endfunction

    function automatic logic [7:0] init_byte(input logic [2:0] step);
        logic [7:0] value;
        case (step)
            3'd0:    value = 8'h03;
            3'd1:    value = 8'h03;
            3'd2:    value = 8'h02;
            3'd3:    value = 8'h28;
            3'd4:    value = 8'h01;
            3'd5:    value = 8'h0C;
            default: value = 8'h06;
        endcase
        return value;
    endfunction

    function automatic logic [4:0] init_wait(input logic [2:0] step);
        logic [4:0] value;
        case (step)
            3'd0:    value = 5'd16;
            3'd1:    value = 5'd5;
            3'd2:    value = 5'd1;
            default: value = 5'd0;
        endcase
        return value;
    endfunction

endpackage

// ----- src/char_lcd_4bit_interface_core.sv -----
// An accepted byte request goes to a queue slot; the back end then registers its strobes.
// Strobes follow one per cycle while the queue holds bytes; a byte is sent as two strobes.
// Number print passes each digit through the divide-by-ten multiply and divide states.
// busy is high while a print or init is being expanded or while the byte queue is full.
// The receiver cannot stall, so every strobe is shown for exactly one cycle.
// Reset (synchronous, active low) empties the queue and returns both parts to idle.
// ----------------------------------------------------------------------------
// char_lcd_4bit_interface_core
// Turns display requests into 4-bit bus nibble strobes for a 20x4 character
// LCD: data, command bytes, cursor moves, clear, decimal print and init.
// ----------------------------------------------------------------------------
module char_lcd_4bit_interface_core
    import lcd4_pkg::*;
#(
    parameter int DIGITS_MAX = 10
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_req    i_req,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    // The front end classifies each accepted request and expands it into
    // bytes: one for data, command, clear and on-screen cursor moves, seven
    // for init, one per decimal digit (plus a leading zero below ten) for
    // print. Bytes carry register select, the init wait and the end mark.
    logic    w_push;
    t_qentry w_push_data;
    logic    w_pop;
    t_qentry w_head;
    logic    w_full;
    logic    w_empty;

    lcd4_front #(
        .DIGITS_MAX (DIGITS_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .i_full      (w_full),
        .busy        (busy),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // The queue lets the front accept the next request, or keep working on
    // digits, while the back end is still sending strobes.
    lcd4_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_full      (w_full),
        .o_empty     (w_empty)
    );

    // The back end splits each byte into a high-nibble beat carrying the
    // wait and a low-nibble beat carrying the end mark. Each beat is shown
    // for exactly one cycle, since the receiver cannot stall.
    lcd4_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ----- src/lcd4_queue.sv -----
// ----------------------------------------------------------------------------
// lcd4_queue
// Short first-word-fall-through queue of bytes between the front and back.
// ----------------------------------------------------------------------------
module lcd4_queue
    import lcd4_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_qentry i_push_data,
    input  logic    i_pop,
    output t_qentry o_head,
    output logic    o_full,
    output logic    o_empty
);

    t_qentry           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // The front only writes when there is room, the back only reads a filled slot.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue read while empty");

    // The fill count never runs past the number of slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count past depth");

endmodule

// ----- src/lcd4_front.sv -----
// ----------------------------------------------------------------------------
// lcd4_front
// Accepts requests, classifies them and turns each into queued bytes; holds
// the decimal digit extractor for number printing.
// ----------------------------------------------------------------------------
module lcd4_front
    import lcd4_pkg::*;
#(
    parameter int DIGITS_MAX = 10
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_req    i_req,
    input  logic    i_full,
    output logic    busy,
    output logic    o_push,
    output t_qentry o_push_data
);

    localparam int CNT_W = $clog2(DIGITS_MAX + 1);
    localparam int IDX_W = (DIGITS_MAX > 1) ? $clog2(DIGITS_MAX) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_EMIT,
        S_INIT
    } t_state;

    t_state           r_state, n_state;
    logic [31:0]      r_val, n_val;
    logic [28:0]      r_quot, n_quot;
    logic             r_lead, n_lead;
    logic [CNT_W-1:0] r_ndig, n_ndig;
    logic [2:0]       r_step, n_step;
    logic [3:0]       r_dig [DIGITS_MAX];

    logic             w_accept;
    logic [63:0]      w_prod;
    logic [31:0]      w_q10;
    logic [31:0]      w_rem;
    logic [3:0]       w_digit;
    logic             w_dig_we;
    logic [CNT_W-1:0] w_rd_cnt;
    logic [IDX_W-1:0] w_rd_idx;
    logic [IDX_W-1:0] w_wr_idx;

    assign busy     = (r_state != S_IDLE) || i_full;
    assign w_accept = start && !busy;

    // Quotient by ten through the reciprocal; the remainder is taken next cycle.
    assign w_prod   = 64'(r_val) * 64'(RECIP10);
    assign w_q10    = {r_quot, 3'b000} + {2'b00, r_quot, 1'b0};
    assign w_rem    = r_val - w_q10;
    assign w_digit  = w_rem[3:0];
    assign w_dig_we = (r_state == S_DIV) && (r_ndig < CNT_W'(DIGITS_MAX));
    assign w_wr_idx = r_ndig[IDX_W-1:0];
    assign w_rd_cnt = r_ndig - 1'b1;
    assign w_rd_idx = w_rd_cnt[IDX_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        n_quot      = r_quot;
        n_lead      = r_lead;
        n_ndig      = r_ndig;
        n_step      = r_step;
        o_push      = 1'b0;
        o_push_data = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.cmd)
                        CMD_DATA: begin
                            o_push      = 1'b1;
                            o_push_data = '{RS_DATA, i_req.byte_value, 5'd0, 1'b1};
                        end
                        CMD_BYTE: begin
                            o_push      = 1'b1;
                            o_push_data = '{RS_COMMAND, i_req.byte_value, 5'd0, 1'b1};
                        end
                        CMD_CURSOR: begin
                            if (i_req.row <= ROW_MAX && i_req.column <= COL_MAX) begin
                                o_push      = 1'b1;
                                o_push_data = '{RS_COMMAND,
                                                CURSOR_FLAG | (row_base(i_req.row[1:0])
                                                    + {3'b000, i_req.column}),
                                                5'd0, 1'b1};
                            end
                        end
                        CMD_CLEAR: begin
                            o_push      = 1'b1;
                            o_push_data = '{RS_COMMAND, LCD_CLEAR, 5'd0, 1'b1};
                        end
                        CMD_PRINT: begin
                            n_val   = i_req.number;
                            n_lead  = (i_req.number < TEN);
                            n_ndig  = '0;
                            n_state = S_MUL;
                        end
                        CMD_INIT: begin
                            n_step  = '0;
                            n_state = S_INIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL: begin
                n_quot  = w_prod[63:RECIP_SHIFT];
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_dig_we) begin
                    n_ndig = r_ndig + 1'b1;
                end
                n_val   = {3'b000, r_quot};
                n_state = (r_quot == '0) ? S_EMIT : S_MUL;
            end
            S_EMIT: begin
                if (!i_full) begin
                    o_push = 1'b1;
                    if (r_lead) begin
                        o_push_data = '{RS_DATA, ASCII_ZERO, 5'd0, 1'b0};
                        n_lead      = 1'b0;
                    end else begin
                        o_push_data = '{RS_DATA, ASCII_ZERO + {4'b0000, r_dig[w_rd_idx]},
                                        5'd0, (r_ndig == CNT_W'(1))};
                        n_ndig      = w_rd_cnt;
                        if (r_ndig == CNT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_INIT: begin
                if (!i_full) begin
                    o_push      = 1'b1;
                    o_push_data = '{RS_COMMAND, init_byte(r_step), init_wait(r_step),
                                    (r_step == INIT_LAST_STEP)};
                    n_step      = r_step + 1'b1;
                    if (r_step == INIT_LAST_STEP) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lead  <= 1'b0;
            r_ndig  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_lead  <= n_lead;
            r_ndig  <= n_ndig;
            r_step  <= n_step;
        end
        r_val  <= n_val;
        r_quot <= n_quot;
    end

    // Digits are stored least significant first and read back in reverse.
    always_ff @(posedge i_clk) begin
        if (w_dig_we) begin
            r_dig[w_wr_idx] <= w_digit;
        end
    end

endmodule

// ----- src/lcd4_back.sv -----
// ----------------------------------------------------------------------------
// lcd4_back
// Drains queued bytes and sends each as two nibble strobes, high nibble first.
// ----------------------------------------------------------------------------
module lcd4_back
    import lcd4_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qentry i_head,
    input  logic    i_empty,
    output logic    o_pop,
    output logic    o_strobe,
    output t_result o_result
);

    logic    r_low_pend, n_low_pend;
    logic    r_strobe, n_strobe;
    t_qentry r_hold, n_hold;
    t_result r_result, n_result;

    assign o_pop    = !r_low_pend && !i_empty;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    always_comb begin
        n_low_pend = r_low_pend;
        n_hold     = r_hold;
        n_strobe   = 1'b0;
        n_result   = r_result;
        if (r_low_pend) begin
            n_strobe   = 1'b1;
            n_result   = '{r_hold.reg_select, r_hold.data[3:0], 5'd0, r_hold.last};
            n_low_pend = 1'b0;
        end else if (o_pop) begin
            n_strobe   = 1'b1;
            n_result   = '{i_head.reg_select, i_head.data[7:4], i_head.wait_ms, 1'b0};
            n_hold     = i_head;
            n_low_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_pend <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_low_pend <= n_low_pend;
            r_strobe   <= n_strobe;
        end
        r_hold   <= n_hold;
        r_result <= n_result;
    end

    // A pending low nibble always goes out in the next cycle.
    a_low_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low_pend |=> o_strobe)
        else $error("low nibble strobe missing");

    // The end-of-request mark only rides on a low nibble.
    a_last_on_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> !r_low_pend)
        else $error("last flag on a high nibble");

    // An init wait only precedes a high nibble.
    a_wait_on_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.wait_before_ms != 5'd0) |-> r_low_pend)
        else $error("wait attached to a low nibble");

endmodule

// ----- tb/char_lcd_4bit_interface_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_4bit_interface_core_test
// Self-checking bench for the 4-bit character LCD front end. A table of
// directed requests covers every request code, the bus extremes, cursor
// limits, unknown codes, short and long numbers and init. A random run of
// requests follows. Every strobe is checked against literal table bytes or an
// in-bench predictor that expands a request into its nibble strobes.
// ----------------------------------------------------------------------------
module char_lcd_4bit_interface_core_test;
    import lcd4_pkg::*;

    localparam int  DIGIT_LIMIT   = 10;
    localparam int  RANDOM_ITEMS  = 95;
    localparam int  DRAIN_CYCLES  = 100;
    localparam int  REPORT_LIMIT  = 10;
    localparam int  N_DIRECTED    = 25;

    // Request codes that the block does not define; they must stay silent.
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    // DDRAM start address of each display row, and the power-up byte run
    // with the extra wait that comes before the first strobe of each byte.
    localparam logic [7:0] ROW_START [4] = '{8'h00, 8'h40, 8'h14, 8'h54};
    localparam logic [7:0] POWER_UP_BYTES [7] =
        '{8'h03, 8'h03, 8'h02, 8'h28, 8'h01, 8'h0C, 8'h06};
    localparam logic [4:0] POWER_UP_WAITS [7] =
        '{5'd16, 5'd5, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0};

    // How a row of the directed table is checked: through the predictor,
    // as one literal byte typed into the table, or as a request that must
    // produce no strobe at all.
    typedef enum logic [1:0] {
        BY_PREDICTOR,
        ONE_BYTE,
        SILENT
    } t_check_kind;

    typedef struct packed {
        t_req        req;
        t_check_kind kind;
        logic        rs;
        logic [7:0]  value;
    } t_directed_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_req    i_req;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    // Strobes that accepted requests still owe, oldest first.
    t_result strobes_due [$];
    int      error_count;
    int      burst_left;

    t_directed_row directed_rows [N_DIRECTED];

    char_lcd_4bit_interface_core #(
        .DIGITS_MAX (DIGIT_LIMIT)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs or stops taking requests.
    initial begin
        #2ms;
        $display("char_lcd_4bit_interface_core_test: FAIL");
        $finish;
    end

    function automatic t_req mk_req(input logic [2:0] cmd, input logic [7:0] value,
                                    input logic [2:0] row, input logic [4:0] column,
                                    input logic [31:0] number);
        t_req r;
        r.cmd        = cmd;
        r.byte_value = value;
        r.row        = row;
        r.column     = column;
        r.number     = number;
        return r;
    endfunction

    // Expands one request into the strobes it must produce and queues them.
    // Returns the number of strobes queued.
    function automatic int predict_strobes(input t_req r);
        t_qentry     bytes [$];
        logic [3:0]  digits [$];
        logic [31:0] rest;
        t_result     s;
        int          n;
        n = 0;
        case (r.cmd)
            CMD_DATA: begin
                bytes.push_back('{RS_DATA, r.byte_value, 5'd0, 1'b0});
            end
            CMD_BYTE: begin
                bytes.push_back('{RS_COMMAND, r.byte_value, 5'd0, 1'b0});
            end
            CMD_CURSOR: begin
                if (r.row <= ROW_MAX && r.column <= COL_MAX) begin
                    bytes.push_back('{RS_COMMAND,
                        CURSOR_FLAG | (ROW_START[r.row[1:0]] + {3'b000, r.column}),
                        5'd0, 1'b0});
                end
            end
            CMD_CLEAR: begin
                bytes.push_back('{RS_COMMAND, LCD_CLEAR, 5'd0, 1'b0});
            end
            CMD_PRINT: begin
                // Single-digit values get a leading zero character.
                if (r.number < 32'd10) begin
                    bytes.push_back('{RS_DATA, ASCII_ZERO, 5'd0, 1'b0});
                end
                // Digits come out least significant first; keep only the
                // lowest DIGIT_LIMIT of them, stored most significant first.
                rest = r.number;
                do begin
                    if (digits.size() < DIGIT_LIMIT) begin
                        digits.push_front(4'(rest % 32'd10));
                    end
                    rest = rest / 32'd10;
                end while (rest != 32'd0);
                foreach (digits[i]) begin
                    bytes.push_back('{RS_DATA, ASCII_ZERO + {4'h0, digits[i]}, 5'd0, 1'b0});
                end
            end
            CMD_INIT: begin
                for (int i = 0; i < 7; i++) begin
                    bytes.push_back('{RS_COMMAND, POWER_UP_BYTES[i], POWER_UP_WAITS[i],
                                      1'b0});
                end
            end
            default: begin
            end
        endcase
        // Each byte is two beats, high nibble first; only the high nibble
        // carries the extra wait, and only the final beat carries last.
        foreach (bytes[i]) begin
            s.reg_select     = bytes[i].reg_select;
            s.nibble         = bytes[i].data[7:4];
            s.wait_before_ms = bytes[i].wait_ms;
            s.last           = 1'b0;
            strobes_due.push_back(s);
            s.nibble         = bytes[i].data[3:0];
            s.wait_before_ms = 5'd0;
            s.last           = (i == bytes.size() - 1);
            strobes_due.push_back(s);
            n += 2;
        end
        return n;
    endfunction

    task automatic report_error(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("[%0t] error: %s", $realtime, what);
        end
    endtask

    // Result checker: a strobe is taken at the rising edge that ends its cycle.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1) begin
            if ($isunknown(o_strobe)) begin
                report_error("strobe is unknown");
            end else if (o_strobe) begin
                if (strobes_due.size() == 0) begin
                    report_error($sformatf("unexpected strobe rs=%0b nib=%h wait=%0d last=%0b",
                        o_result.reg_select, o_result.nibble,
                        o_result.wait_before_ms, o_result.last));
                end else begin
                    want = strobes_due.pop_front();
                    if (o_result.reg_select !== want.reg_select
                            || o_result.nibble !== want.nibble
                            || o_result.wait_before_ms !== want.wait_before_ms
                            || o_result.last !== want.last) begin
                        report_error($sformatf(
                            {"strobe exp rs=%0b nib=%h wait=%0d last=%0b",
                             " got rs=%0b nib=%h wait=%0d last=%0b"},
                            want.reg_select, want.nibble, want.wait_before_ms, want.last,
                            o_result.reg_select, o_result.nibble,
                            o_result.wait_before_ms, o_result.last));
                    end
                end
            end
        end
    end

    // Puts one request on the bus at the falling edge and holds it until a
    // rising edge sees busy low. Returns in the time step of the accept.
    task automatic issue_request(input t_req r);
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Drops start for the given number of cycles; zero keeps start high so
    // the next request follows back to back.
    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Holds off until every owed strobe has come out.
    task automatic drain_results();
        pause_sender(1);
        while (strobes_due.size() != 0) @(posedge i_clk);
    endtask

    // Sender gap: mostly none or short, a few long, and now and then a
    // burst of back-to-back requests.
    function automatic int sender_gap();
        int pick;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            burst_left = $urandom_range(8, 15);
            return 0;
        end
        if (pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_req random_req();
        t_req r;
        int   pick;
        r.byte_value = 8'($urandom);
        r.row        = 3'($urandom_range(0, 7));
        r.column     = 5'($urandom_range(0, 31));
        pick         = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
            0:       r.number = $urandom_range(0, 9);
            1:       r.number = $urandom_range(10, 99999);
            default: r.number = $urandom;
        endcase
        if (pick < 15)      r.cmd = CMD_DATA;
        else if (pick < 25) r.cmd = CMD_BYTE;
        else if (pick < 45) begin
            r.cmd = CMD_CURSOR;
            // Most cursor moves land on the display; the rest are random
            // and may fall off it.
            if ($urandom_range(0, 4) != 0) begin
                r.row    = 3'($urandom_range(0, 3));
                r.column = 5'($urandom_range(0, 19));
            end
        end
        else if (pick < 55) r.cmd = CMD_CLEAR;
        else if (pick < 85) r.cmd = CMD_PRINT;
        else if (pick < 92) r.cmd = CMD_INIT;
        else                r.cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
        return r;
    endfunction

    initial begin
        int      counted;
        t_result s;
        t_req    r;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        error_count = 0;
        burst_left  = 0;

        // Directed table. Byte-level rows carry their expected byte; cursor
        // addresses are 0x80 plus row start plus column.
        directed_rows = '{
            '{mk_req(CMD_DATA,   8'h00, 3'd0, 5'd0,  32'd0),        ONE_BYTE, RS_DATA,    8'h00},
            '{mk_req(CMD_DATA,   8'hFF, 3'd7, 5'd31, 32'hFFFF_FFFF), ONE_BYTE, RS_DATA,    8'hFF},
            '{mk_req(CMD_BYTE,   8'hA5, 3'd0, 5'd0,  32'd0),        ONE_BYTE, RS_COMMAND, 8'hA5},
            '{mk_req(CMD_BYTE,   8'h5A, 3'd5, 5'd21, 32'h5555_5555), ONE_BYTE, RS_COMMAND, 8'h5A},
            '{mk_req(CMD_CLEAR,  8'hFF, 3'd7, 5'd31, 32'hFFFF_FFFF), ONE_BYTE, RS_COMMAND, 8'h01},
            '{mk_req(CMD_CURSOR, 8'h00, 3'd0, 5'd0,  32'd0),        ONE_BYTE, RS_COMMAND, 8'h80},
            '{mk_req(CMD_CURSOR, 8'hFF, 3'd1, 5'd5,  32'd0),        ONE_BYTE, RS_COMMAND, 8'hC5},
            '{mk_req(CMD_CURSOR, 8'h00, 3'd2, 5'd19, 32'hFFFF_FFFF), ONE_BYTE, RS_COMMAND, 8'hA7},
            '{mk_req(CMD_CURSOR, 8'h00, 3'd3, 5'd19, 32'd0),        ONE_BYTE, RS_COMMAND, 8'hE7},
            '{mk_req(CMD_CURSOR, 8'h00, 3'd3, 5'd0,  32'd0),        ONE_BYTE, RS_COMMAND, 8'hD4},
            // Off the display: row past the last one, column past the last.
            '{mk_req(CMD_CURSOR, 8'h00, 3'd4, 5'd0,  32'd0),        SILENT,   RS_COMMAND, 8'h00},
            '{mk_req(CMD_CURSOR, 8'h00, 3'd0, 5'd20, 32'd0),        SILENT,   RS_COMMAND, 8'h00},
            '{mk_req(CMD_CURSOR, 8'hFF, 3'd7, 5'd31, 32'd0),        SILENT,   RS_COMMAND, 8'h00},
            // Unknown request codes.
            '{mk_req(CMD_SPARE_LO, 8'h41, 3'd1, 5'd1, 32'd1),       SILENT,   RS_COMMAND, 8'h00},
            '{mk_req(CMD_SPARE_HI, 8'hFF, 3'd7, 5'd31, 32'hFFFF_FFFF), SILENT, RS_COMMAND, 8'h00},
            // Numbers: zero and single digits get a leading zero; then the
            // first two-digit value, a mid value and the widest values.
            '{mk_req(CMD_PRINT,  8'h00, 3'd0, 5'd0,  32'd0),        BY_PREDICTOR, RS_DATA, 8'h00},
            '{mk_req(CMD_PRINT,  8'hFF, 3'd7, 5'd31, 32'd7),        BY_PREDICTOR, RS_DATA, 8'h00},
            '{mk_req(CMD_PRINT,  8'h00, 3'd0, 5'd0,  32'd9),        BY_PREDICTOR, RS_DATA, 8'h00},
            '{mk_req(CMD_PRINT,  8'h00, 3'd0, 5'd0,  32'd10),       BY_PREDICTOR, RS_DATA, 8'h00},
            '{mk_req(CMD_PRINT,  8'h00, 3'd0, 5'd0,  32'd99999),    BY_PREDICTOR, RS_DATA, 8'h00},
            '{mk_req(CMD_PRINT,  8'h00, 3'd0, 5'd0,  32'd1000000000), BY_PREDICTOR, RS_DATA, 8'h00},
            '{mk_req(CMD_PRINT,  8'h00, 3'd0, 5'd0,  32'hFFFF_FFFF), BY_PREDICTOR, RS_DATA, 8'h00},
            '{mk_req(CMD_INIT,   8'h00, 3'd0, 5'd0,  32'd0),        BY_PREDICTOR, RS_DATA, 8'h00},
            '{mk_req(CMD_INIT,   8'hFF, 3'd7, 5'd31, 32'hFFFF_FFFF), BY_PREDICTOR, RS_DATA, 8'h00},
            '{mk_req(CMD_DATA,   8'h41, 3'd0, 5'd0,  32'd0),        ONE_BYTE, RS_DATA,    8'h41}
        };

        // Synchronous reset held low, then released at a falling edge.
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Literal rows queue their own expectation at accept.
        foreach (directed_rows[i]) begin
            issue_request(directed_rows[i].req);
            case (directed_rows[i].kind)
                ONE_BYTE: begin
                    s.reg_select     = directed_rows[i].rs;
                    s.nibble         = directed_rows[i].value[7:4];
                    s.wait_before_ms = 5'd0;
                    s.last           = 1'b0;
                    strobes_due.push_back(s);
                    s.nibble         = directed_rows[i].value[3:0];
                    s.last           = 1'b1;
                    strobes_due.push_back(s);
                end
                BY_PREDICTOR: begin
                    void'(predict_strobes(directed_rows[i].req));
                end
                default: begin
                end
            endcase
            pause_sender(sender_gap());
        end

        // Let the block go fully quiet before the random run.
        drain_results();

        // Random part. Every request counts, silent ones included.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            r = random_req();
            issue_request(r);
            void'(predict_strobes(r));
            counted++;
            if ($urandom_range(0, 24) == 0) drain_results();
            else pause_sender(sender_gap());
        end

        // Wait for the last strobes, then give in-flight work time to show
        // any stray output.
        pause_sender(1);
        while (strobes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (strobes_due.size() != 0) begin
            report_error($sformatf("%0d strobes never arrived", strobes_due.size()));
        end
        if (error_count == 0) begin
            $display("char_lcd_4bit_interface_core_test: PASS");
        end else begin
            $display("char_lcd_4bit_interface_core_test: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/lcd4_pkg.sv
src/lcd4_queue.sv
src/lcd4_front.sv
src/lcd4_back.sv
src/char_lcd_4bit_interface_core.sv
tb/char_lcd_4bit_interface_core_test.sv
